[design/qfcn_pkg.sv]
// ----------------------------------------------------------------------------
// qfcn_pkg: shared types and constants of the quad face centroid/normal block
// Holds the back-end sequencer states, register indexes and the fixed widths
// of the normalizing datapath.
// ----------------------------------------------------------------------------
package qfcn_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FACE_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_NORM_SQ = 1'b1;

	localparam int FACE_W   = 16;
	localparam int THRESH_W = 63;
	localparam int NORM_W   = 32;   // output normal component width

	// the largest normalized magnitude lives in [2^31, 2^32)
	localparam int UW         = 32;
	localparam int ACC_W      = 128;
	localparam int RAD_W      = 100; // radicand (sum of u^2) << 32, padded even
	localparam int ROOT_W     = 50;
	localparam int REM_W      = 52;
	localparam int M_W        = 49;
	localparam int DREM_W     = 50;
	localparam int QUO_W      = 31;
	// u * 2^46 + m/2 can reach just past 2^78 when u is close to 2^32
	localparam int NUM_W      = 79;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int DIV_STEPS  = QUO_W;
	localparam int CNT_W      = 6;

	localparam logic [QUO_W-1:0] ONE_Q30 = QUO_W'(1) << 30;

	localparam int QDEPTH = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG,
		ST_SQ,
		ST_CMP,
		ST_NORM,
		ST_USQ,
		ST_SQRT,
		ST_DLOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	// weight of a partial product when it is added to the accumulator
	typedef enum logic [1:0] {
		SH_0,
		SH_32,
		SH_62
	} shift_t;

endpackage

[design/qfcn_if.sv]
// ----------------------------------------------------------------------------
// qfcn_if: face and result channels
// Valid/ready channels carrying one quad face and one centroid/normal result.
// ----------------------------------------------------------------------------
interface qfcn_in_if #(parameter int CW = 24);
	logic valid;
	logic ready;
	logic signed [CW-1:0] first_x;
	logic signed [CW-1:0] first_y;
	logic signed [CW-1:0] first_z;
	logic signed [CW-1:0] second_x;
	logic signed [CW-1:0] second_y;
	logic signed [CW-1:0] second_z;
	logic signed [CW-1:0] third_x;
	logic signed [CW-1:0] third_y;
	logic signed [CW-1:0] third_z;
	logic signed [CW-1:0] fourth_x;
	logic signed [CW-1:0] fourth_y;
	logic signed [CW-1:0] fourth_z;

	modport source (output valid, input ready,
		output first_x, first_y, first_z, second_x, second_y, second_z,
		output third_x, third_y, third_z, fourth_x, fourth_y, fourth_z);
	modport sink (input valid, output ready,
		input first_x, first_y, first_z, second_x, second_y, second_z,
		input third_x, third_y, third_z, fourth_x, fourth_y, fourth_z);
endinterface

interface qfcn_out_if #(parameter int CW = 24);
	logic valid;
	logic ready;
	logic signed [CW-1:0] centroid_x;
	logic signed [CW-1:0] centroid_y;
	logic signed [CW-1:0] centroid_z;
	logic signed [31:0]   normal_x;
	logic signed [31:0]   normal_y;
	logic signed [31:0]   normal_z;
	logic                 degenerate;
	logic                 last_face;

	modport source (output valid, input ready,
		output centroid_x, centroid_y, centroid_z, normal_x, normal_y, normal_z,
		output degenerate, last_face);
	modport sink (input valid, output ready,
		input centroid_x, centroid_y, centroid_z, normal_x, normal_y, normal_z,
		input degenerate, last_face);
endinterface

[design/qfcn_front.sv]
// ----------------------------------------------------------------------------
// qfcn_front: face intake
// Two-stage pipe: centroid, edge vectors and face position, then the cross
// product. Pushes one packed beat per face into the queue.
// ----------------------------------------------------------------------------
module qfcn_front #(
	parameter int CW = 24,
	localparam int XW = 2*CW + 3,
	localparam int DW = 1 + 3*CW + 3*XW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	qfcn_in_if.sink                   vert,
	input  logic [qfcn_pkg::FACE_W-1:0] face_count,
	output logic                      q_valid,
	input  logic                      q_ready,
	output logic [DW-1:0]             q_data
);
	import qfcn_pkg::*;

	logic              v_s1, v_s2;
	logic              last_s1, last_s2;
	logic signed [CW-1:0] cen_s1 [3];
	logic signed [CW-1:0] cen_s2 [3];
	logic signed [CW:0]   d1_s1 [3];
	logic signed [CW:0]   d2_s1 [3];
	logic signed [XW-1:0] c_s2 [3];
	logic [FACE_W-1:0] face_idx_q;
	logic [FACE_W-1:0] face_nxt;
	logic              adv1, adv2, take;
	logic signed [CW+1:0]   sum [3];
	logic signed [2*CW+1:0] p [6];

	assign adv2 = !v_s2 || q_ready;
	assign adv1 = !v_s1 || adv2;
	assign vert.ready = adv1;
	assign take = vert.valid && adv1;
	assign face_nxt = face_idx_q + FACE_W'(1);

	always_comb begin
		sum[0] = (CW+2)'(vert.first_x) + (CW+2)'(vert.second_x)
			+ (CW+2)'(vert.third_x) + (CW+2)'(vert.fourth_x);
		sum[1] = (CW+2)'(vert.first_y) + (CW+2)'(vert.second_y)
			+ (CW+2)'(vert.third_y) + (CW+2)'(vert.fourth_y);
		sum[2] = (CW+2)'(vert.first_z) + (CW+2)'(vert.second_z)
			+ (CW+2)'(vert.third_z) + (CW+2)'(vert.fourth_z);
	end

	always_comb begin
		p[0] = d1_s1[1] * d2_s1[2];
		p[1] = d2_s1[1] * d1_s1[2];
		p[2] = d1_s1[2] * d2_s1[0];
		p[3] = d1_s1[0] * d2_s1[2];
		p[4] = d1_s1[0] * d2_s1[1];
		p[5] = d1_s1[1] * d2_s1[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			face_idx_q <= '0;
		end else begin
			if (adv1) v_s1 <= vert.valid;
			if (adv2) v_s2 <= v_s1;
			if (take) face_idx_q <= (face_nxt == face_count) ? '0 : face_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_s1  <= (face_nxt == face_count);
			for (int a = 0; a < 3; a++) cen_s1[a] <= sum[a][CW+1:2];
			d1_s1[0] <= (CW+1)'(vert.second_x) - (CW+1)'(vert.first_x);
			d1_s1[1] <= (CW+1)'(vert.second_y) - (CW+1)'(vert.first_y);
			d1_s1[2] <= (CW+1)'(vert.second_z) - (CW+1)'(vert.first_z);
			d2_s1[0] <= (CW+1)'(vert.third_x) - (CW+1)'(vert.first_x);
			d2_s1[1] <= (CW+1)'(vert.third_y) - (CW+1)'(vert.first_y);
			d2_s1[2] <= (CW+1)'(vert.third_z) - (CW+1)'(vert.first_z);
		end
		if (adv2 && v_s1) begin
			last_s2 <= last_s1;
			for (int a = 0; a < 3; a++) cen_s2[a] <= cen_s1[a];
			c_s2[0] <= XW'(p[0]) - XW'(p[1]);
			c_s2[1] <= XW'(p[2]) - XW'(p[3]);
			c_s2[2] <= XW'(p[4]) - XW'(p[5]);
		end
	end

	assign q_valid = v_s2;
	assign q_data  = {last_s2, cen_s2[0], cen_s2[1], cen_s2[2], c_s2[0], c_s2[1], c_s2[2]};

endmodule

[design/qfcn_fifo.sv]
// ----------------------------------------------------------------------------
// qfcn_fifo: face queue
// Short register queue between intake and normalizer.
// ----------------------------------------------------------------------------
module qfcn_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output logic [DW-1:0] rd_data
);
	import qfcn_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	logic [DW-1:0] mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign wr_ready = (cnt_q != (PW+1)'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

[design/qfcn_back.sv]
// ----------------------------------------------------------------------------
// qfcn_back: normalizer
// Sequencer around one shared 32x32 multiplier, a radix-2 square root and a
// bit-serial divider; degeneracy check and result register.
// ----------------------------------------------------------------------------
module qfcn_back #(
	parameter int CW = 24,
	parameter int FB = 16,
	localparam int XW = 2*CW + 3,
	localparam int DW = 1 + 3*CW + 3*XW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [qfcn_pkg::THRESH_W-1:0] min_norm_sq,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic [DW-1:0]                 q_data,
	qfcn_out_if.source                    res
);
	import qfcn_pkg::*;

	localparam int MW  = (XW > 64) ? XW : 64;
	localparam int TK  = 4*FB - 64;
	localparam int SHL = (TK >= 0) ? TK : 0;
	localparam int SHR = (TK >= 0) ? 0 : -TK;

	state_t state_q, state_d;

	logic signed [XW-1:0] cx_q [3];
	logic [MW-1:0]        mag_q [3];
	logic [MW-1:0]        mag_n [3];
	logic [2:0]           neg_q;
	logic signed [CW-1:0] cen_q [3];
	logic                 last_q, degen_q;
	logic [NORM_W-1:0]    nrm_q [3];

	logic [1:0]       idx_q, part_q, sel;
	logic [63:0]      p_q;
	shift_t           psh_q, psh_d;
	logic             pv_q, issuing;
	logic [UW-1:0]    mop_a, mop_b;
	logic [ACC_W-1:0] acc_q, tadj, pterm;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q, r2, trial;
	logic [ROOT_W-1:0] root_q;
	logic              rge;
	logic [CNT_W-1:0]  cnt_q;
	logic [M_W-1:0]    m_q;

	logic [NUM_W-1:0]  num;
	logic [DREM_W-1:0] drem_q, d2;
	logic [QUO_W-1:0]  dnum_q, quo_q, q_fin, q_clip;
	logic              dge;

	logic [MW-1:0] or_w;
	logic          big_n, norm_done, mul_done, degen_w, out_free, out_load;

	logic                 res_v_q;
	logic signed [CW-1:0] cen_o [3];
	logic [NORM_W-1:0]    nrm_o [3];
	logic                 degen_o, last_o;

	// magnitudes of the cross product
	always_comb begin
		big_n = 1'b0;
		for (int a = 0; a < 3; a++) begin
			mag_n[a] = MW'(cx_q[a][XW-1] ? (~cx_q[a] + XW'(1)) : cx_q[a]);
			big_n    = big_n | (|mag_n[a][MW-1:62]);
		end
	end

	assign tadj      = (ACC_W'(min_norm_sq) << SHL) >> SHR;
	assign degen_w   = (acc_q <= tadj);
	assign or_w      = mag_q[0] | mag_q[1] | mag_q[2];
	assign norm_done = (or_w[MW-1:UW] == '0) && or_w[UW-1];
	assign sel       = (idx_q == 2'd3) ? 2'd2 : idx_q;
	assign issuing   = ((state_q == ST_SQ) || (state_q == ST_USQ)) && (idx_q != 2'd3);
	assign mul_done  = (idx_q == 2'd3) && !pv_q;

	// multiplier operand select
	always_comb begin
		mop_a = mag_q[sel][UW-1:0];
		mop_b = mag_q[sel][UW-1:0];
		psh_d = SH_0;
		if (state_q == ST_SQ) begin
			unique case (part_q)
				2'd0: begin
					mop_a = UW'(mag_q[sel][61:31]);
					mop_b = UW'(mag_q[sel][61:31]);
					psh_d = SH_62;
				end
				2'd1: begin
					mop_a = UW'(mag_q[sel][61:31]);
					mop_b = UW'(mag_q[sel][30:0]);
					psh_d = SH_32;
				end
				default: begin
					mop_a = UW'(mag_q[sel][30:0]);
					mop_b = UW'(mag_q[sel][30:0]);
					psh_d = SH_0;
				end
			endcase
		end
	end

	always_comb begin
		unique case (psh_q)
			SH_62:   pterm = ACC_W'(p_q) << 62;
			SH_32:   pterm = ACC_W'(p_q) << 32;
			default: pterm = ACC_W'(p_q);
		endcase
	end

	// square root step
	assign r2    = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial = {root_q, 2'b01};
	assign rge   = (r2 >= trial);

	// divide step
	assign num    = {mag_q[sel][UW-1:0], 46'b0} + NUM_W'(m_q >> 1);
	assign d2     = {drem_q[DREM_W-2:0], dnum_q[QUO_W-1]};
	assign dge    = (d2 >= DREM_W'(m_q));
	assign q_fin  = {quo_q[QUO_W-2:0], dge};
	assign q_clip = (q_fin > ONE_Q30) ? ONE_Q30 : q_fin;

	assign out_free = !res_v_q || res.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_MAG;
			ST_MAG:   state_d = big_n ? ST_NORM : ST_SQ;
			ST_SQ:    if (mul_done) state_d = ST_CMP;
			ST_CMP:   state_d = degen_w ? ST_OUT : ST_NORM;
			ST_NORM:  if (norm_done) state_d = ST_USQ;
			ST_USQ:   if (mul_done) state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == CNT_W'(SQRT_STEPS-1)) state_d = ST_DLOAD;
			ST_DLOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS-1))
					state_d = (idx_q == 2'd2) ? ST_OUT : ST_DLOAD;
			end
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_ready  = (state_q == ST_IDLE);
		out_load = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pv_q    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_q    <= issuing;
			if (out_load) res_v_q <= 1'b1;
			else if (res.ready) res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issuing) begin
			p_q   <= 64'(mop_a) * 64'(mop_b);
			psh_q <= psh_d;
		end
		if (pv_q) acc_q <= acc_q + pterm;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					last_q <= q_data[DW-1];
					for (int a = 0; a < 3; a++) begin
						cen_q[a] <= q_data[3*XW + (2-a)*CW +: CW];
						cx_q[a]  <= q_data[(2-a)*XW +: XW];
					end
				end
			end
			ST_MAG: begin
				for (int a = 0; a < 3; a++) begin
					mag_q[a] <= mag_n[a];
					neg_q[a] <= cx_q[a][XW-1];
				end
				degen_q <= 1'b0;
				idx_q   <= 2'd0;
				part_q  <= 2'd0;
				acc_q   <= '0;
			end
			ST_SQ: begin
				if (issuing) begin
					if (part_q == 2'd2) begin
						part_q <= 2'd0;
						idx_q  <= idx_q + 2'd1;
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
			end
			ST_CMP: begin
				degen_q <= degen_w;
				for (int a = 0; a < 3; a++) nrm_q[a] <= '0;
			end
			ST_NORM: begin
				// coarse then fine shifts until the largest lands in [2^31, 2^32)
				for (int a = 0; a < 3; a++) begin
					if (|or_w[MW-1:40])          mag_q[a] <= mag_q[a] >> 8;
					else if (|or_w[MW-1:UW])     mag_q[a] <= mag_q[a] >> 1;
					else if (or_w[UW-1:24] == '0) mag_q[a] <= mag_q[a] << 8;
					else if (!or_w[UW-1])        mag_q[a] <= mag_q[a] << 1;
				end
				idx_q <= 2'd0;
				acc_q <= '0;
			end
			ST_USQ: begin
				if (issuing) idx_q <= idx_q + 2'd1;
				if (mul_done) begin
					rad_q  <= {2'b0, acc_q[65:0], 32'b0};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
					idx_q  <= 2'd0;
				end
			end
			ST_SQRT: begin
				rem_q  <= rge ? (r2 - trial) : r2;
				root_q <= {root_q[ROOT_W-2:0], rge};
				rad_q  <= rad_q << 2;
				cnt_q  <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SQRT_STEPS-1))
					m_q <= {root_q[M_W-2:0], rge};
			end
			ST_DLOAD: begin
				drem_q <= DREM_W'(num[NUM_W-1:QUO_W]);
				dnum_q <= num[QUO_W-1:0];
				quo_q  <= '0;
				cnt_q  <= '0;
			end
			ST_DIV: begin
				drem_q <= dge ? (d2 - DREM_W'(m_q)) : d2;
				quo_q  <= q_fin;
				dnum_q <= dnum_q << 1;
				cnt_q  <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS-1)) begin
					nrm_q[sel] <= neg_q[sel] ? (NORM_W'(0) - NORM_W'(q_clip)) : NORM_W'(q_clip);
					idx_q      <= idx_q + 2'd1;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					for (int a = 0; a < 3; a++) begin
						cen_o[a] <= cen_q[a];
						nrm_o[a] <= nrm_q[a];
					end
					degen_o <= degen_q;
					last_o  <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid      = res_v_q;
	assign res.centroid_x = cen_o[0];
	assign res.centroid_y = cen_o[1];
	assign res.centroid_z = cen_o[2];
	assign res.normal_x   = nrm_o[0];
	assign res.normal_y   = nrm_o[1];
	assign res.normal_z   = nrm_o[2];
	assign res.degenerate = degen_o;
	assign res.last_face  = last_o;

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NORM |-> or_w != '0)
		else $error("normalizing an all-zero cross product");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> !root_q[ROOT_W-1])
		else $error("square root out of range");

	a_drem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> drem_q < DREM_W'(m_q))
		else $error("divider remainder not below divisor");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_W'(DIV_STEPS-1)) |-> q_fin <= ONE_Q30)
		else $error("normal component above one");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && degen_o) |-> (nrm_o[0] == '0 && nrm_o[1] == '0 && nrm_o[2] == '0))
		else $error("degenerate result with nonzero normal");

endmodule

[design/quad_face_centroid_normal.sv]
// ----------------------------------------------------------------------------
// quad_face_centroid_normal: centroid and unit normal of quad faces
// Per face: vertex average and unit normal of (v2-v1) x (v3-v1), with a
// degeneracy flag and a last-face marker for meshes of face_count faces.
// ----------------------------------------------------------------------------
// One face beat in gives one result beat out. The intake takes a face every
// cycle, unless stalled by a full queue, into a two-stage pipe (centroid and
// edges, then cross product) and a two-entry queue, so faces keep flowing in
// while the normalizer works. The normalizer handles one face at a time; a
// degenerate face skips the square root and divisions, other faces go
// through magnitude normalization, the shared 32x32 multiplier, the 50-step
// radix-2 square root and three 31-step bit-serial divisions. A finished
// result waits in the output register while the next face is already being
// processed. The normal is Q1.30, rounded to nearest, and is zero with
// degenerate set when the squared cross-product norm does not exceed
// min_norm_sq * 2^-64. last_face marks every face_count-th face (zero means
// 65536); writing face_count does not restart the count.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module quad_face_centroid_normal #(
	parameter int COORD_WIDTH = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	qfcn_in_if.sink                           vert,
	qfcn_out_if.source                        res,
	input  logic                              cfg_we,
	input  logic [qfcn_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qfcn_pkg::THRESH_W-1:0]     cfg_data
);
	import qfcn_pkg::*;

	localparam int XW = 2*COORD_WIDTH + 3;
	localparam int DW = 1 + 3*COORD_WIDTH + 3*XW;

	logic [FACE_W-1:0]   face_count_q;
	logic [THRESH_W-1:0] min_norm_sq_q;

	logic          f_valid, f_ready, b_valid, b_ready;
	logic [DW-1:0] f_data, b_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_count_q  <= FACE_W'(1);
			min_norm_sq_q <= THRESH_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FACE_COUNT:  face_count_q  <= cfg_data[FACE_W-1:0];
				REG_MIN_NORM_SQ: min_norm_sq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// intake: centroid, edges, cross product, face position
	qfcn_front #(.CW(COORD_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vert       (vert),
		.face_count (face_count_q),
		.q_valid    (f_valid),
		.q_ready    (f_ready),
		.q_data     (f_data)
	);

	// decouple intake from the normalizer
	qfcn_fifo #(.DW(DW)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	// normalize, check degeneracy, hold the result beat
	qfcn_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.min_norm_sq (min_norm_sq_q),
		.q_valid     (b_valid),
		.q_ready     (b_ready),
		.q_data      (b_data),
		.res         (res)
	);

endmodule

[test/quad_face_centroid_normal_test.sv]
// ----------------------------------------------------------------------------
// quad_face_centroid_normal_test: self-checking bench for the quad face block
// Drives directed and random faces through the valid/ready channels under
// several face_count/min_norm_sq settings. A bit-exact predictor of centroid,
// unit normal, degenerate flag and last-face marker checks every result beat.
// ----------------------------------------------------------------------------
module quad_face_centroid_normal_test;
	import qfcn_pkg::*;

	localparam int CW = 24;

	typedef struct {
		logic signed [CW-1:0] v [4][3];   // vertex, axis
	} face_t;

	typedef struct {
		logic signed [CW-1:0] centroid [3];
		logic signed [31:0]   normal [3];
		logic                 degenerate;
		logic                 last_face;
	} shade_t;

	// Scoreboard: mirrors the register file and the face counter, keeps the
	// expected results in order of acceptance.
	class face_scoreboard;
		logic [FACE_W-1:0]   face_count;
		logic [THRESH_W-1:0] min_norm_sq;
		logic [FACE_W-1:0]   face_index;
		shade_t              pending [$];
		int                  errors;
		int                  checked;
		int                  degen_seen;
		int                  last_seen;

		function new();
			face_count  = 1;
			min_norm_sq = 1;
			face_index  = 0;
			errors      = 0;
			checked     = 0;
			degen_seen  = 0;
			last_seen   = 0;
		endfunction

		// centroid, unit normal and counter update of one face
		function automatic shade_t shade(face_t f);
			shade_t r;
			logic signed [25:0] sum;
			logic signed [24:0] d1 [3];
			logic signed [24:0] d2 [3];
			logic signed [63:0] c [3];
			logic [63:0] mag [3];
			logic [63:0] u [3];
			logic [63:0] mx, m, t;
			logic [127:0] s, rad, q;
			int len;
			for (int a = 0; a < 3; a++) begin
				sum = f.v[0][a] + f.v[1][a] + f.v[2][a] + f.v[3][a];
				r.centroid[a] = CW'(sum >>> 2);
				d1[a] = f.v[1][a] - f.v[0][a];
				d2[a] = f.v[2][a] - f.v[0][a];
			end
			c[0] = d1[1] * d2[2] - d2[1] * d1[2];
			c[1] = d1[2] * d2[0] - d1[0] * d2[2];
			c[2] = d1[0] * d2[1] - d1[1] * d2[0];
			for (int a = 0; a < 3; a++)
				mag[a] = c[a] < 0 ? 64'(-c[a]) : 64'(c[a]);
			// |c| stays below 2^51, so the squared norm fits easily
			s = 128'(mag[0]) * mag[0] + 128'(mag[1]) * mag[1] + 128'(mag[2]) * mag[2];
			r.degenerate = (s <= 128'(min_norm_sq));
			if (r.degenerate) begin
				for (int a = 0; a < 3; a++) r.normal[a] = '0;
			end else begin
				mx = mag[0];
				if (mag[1] >= mx) mx = mag[1];
				if (mag[2] >= mx) mx = mag[2];
				len = 0;
				for (t = mx; t != 0; t = t >> 1) len++;
				// bring the largest magnitude into [2^31, 2^32)
				for (int a = 0; a < 3; a++)
					u[a] = len > 32 ? mag[a] >> (len - 32) : mag[a] << (32 - len);
				rad = (128'(u[0]) * u[0] + 128'(u[1]) * u[1] + 128'(u[2]) * u[2]) << 32;
				m = 0;
				for (int b = 48; b >= 0; b--) begin
					t = m | (64'd1 << b);
					if (128'(t) * 128'(t) <= rad) m = t;
				end
				for (int a = 0; a < 3; a++) begin
					q = ((128'(u[a]) << 46) + 128'(m >> 1)) / 128'(m);
					if (q > 128'(1 << 30)) q = 128'(1 << 30);
					r.normal[a] = c[a] < 0 ? -32'(q) : 32'(q);
				end
			end
			if (FACE_W'(face_index + 1) == face_count) begin
				r.last_face = 1'b1;
				face_index  = '0;
			end else begin
				r.last_face = 1'b0;
				face_index  = face_index + 1;
			end
			return r;
		endfunction

		function void note_face(face_t f);
			pending.push_back(shade(f));
		endfunction

		function void check_result(shade_t got);
			shade_t exp;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: result beat with nothing expected", $realtime);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.degenerate) degen_seen++;
			if (got.last_face) last_seen++;
			for (int a = 0; a < 3; a++) begin
				if (got.centroid[a] !== exp.centroid[a]) begin
					$display("%0t: centroid[%0d] expected %0d actual %0d", $realtime, a,
						exp.centroid[a], got.centroid[a]);
					errors++;
				end
				if (got.normal[a] !== exp.normal[a]) begin
					$display("%0t: normal[%0d] expected %0d actual %0d", $realtime, a,
						exp.normal[a], got.normal[a]);
					errors++;
				end
			end
			if (got.degenerate !== exp.degenerate) begin
				$display("%0t: degenerate expected %b actual %b", $realtime,
					exp.degenerate, got.degenerate);
				errors++;
			end
			if (got.last_face !== exp.last_face) begin
				$display("%0t: last_face expected %b actual %b", $realtime,
					exp.last_face, got.last_face);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THRESH_W-1:0]  cfg_data;

	qfcn_in_if  #(.CW(CW)) vert ();
	qfcn_out_if #(.CW(CW)) res ();

	quad_face_centroid_normal #(.COORD_WIDTH(CW), .FRAC_BITS(16)) DUT (
		.clk(clk), .arst_n(arst_n), .vert(vert), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	face_scoreboard board = new();

	bit steady;      // no idling on either side while set
	bit hold_req;    // ask the receiver for a long hold-off
	int sent;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitors: sample on the edge, before any NBA of this step lands.
	always @(posedge clk) begin
		face_t f;
		if (vert.valid && vert.ready) begin
			f.v[0] = '{vert.first_x,  vert.first_y,  vert.first_z};
			f.v[1] = '{vert.second_x, vert.second_y, vert.second_z};
			f.v[2] = '{vert.third_x,  vert.third_y,  vert.third_z};
			f.v[3] = '{vert.fourth_x, vert.fourth_y, vert.fourth_z};
			board.note_face(f);
		end
	end

	always @(posedge clk) begin
		shade_t g;
		if (res.valid && res.ready) begin
			g.centroid   = '{res.centroid_x, res.centroid_y, res.centroid_z};
			g.normal     = '{res.normal_x, res.normal_y, res.normal_z};
			g.degenerate = res.degenerate;
			g.last_face  = res.last_face;
			board.check_result(g);
		end
	end

	// Receiver: random stalls, none while steady; on request hold off for a
	// long stretch so the intake queue fills and the block stalls its input.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
				res.ready <= 1'b1;
			end else begin
				res.ready <= steady || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	// Hold the face on the channel until the block takes it.
	task automatic send_face(face_t f);
		if (!steady && $urandom_range(0, 99) < 14) begin
			vert.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		vert.valid    <= 1'b1;
		vert.first_x  <= f.v[0][0]; vert.first_y  <= f.v[0][1]; vert.first_z  <= f.v[0][2];
		vert.second_x <= f.v[1][0]; vert.second_y <= f.v[1][1]; vert.second_z <= f.v[1][2];
		vert.third_x  <= f.v[2][0]; vert.third_y  <= f.v[2][1]; vert.third_z  <= f.v[2][2];
		vert.fourth_x <= f.v[3][0]; vert.fourth_y <= f.v[3][1]; vert.fourth_z <= f.v[3][2];
		@(posedge clk);
		while (!vert.ready) @(posedge clk);
		sent++;
	endtask

	// Drain: let every expected result arrive, then leave a margin.
	task automatic drain();
		vert.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_FACE_COUNT) board.face_count = val[FACE_W-1:0];
		else board.min_norm_sq = val;
		cfg_we <= 1'b0;
	endtask

	function automatic face_t make_face(int signed p [12]);
		face_t f;
		for (int i = 0; i < 12; i++) f.v[i / 3][i % 3] = CW'(p[i]);
		return f;
	endfunction

	// Mostly random full-range faces, plus small faces near the threshold,
	// collinear (degenerate) faces and corner values.
	function automatic face_t random_face();
		face_t f;
		int kind;
		int signed k;
		logic signed [CW-1:0] corner [4];
		corner = '{24'sh800000, 24'sh7fffff, 24'sd0, -24'sd1};
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++)
			for (int a = 0; a < 3; a++)
				f.v[i][a] = CW'($urandom);
		if (kind >= 6 && kind <= 7) begin
			for (int i = 1; i < 4; i++)
				for (int a = 0; a < 3; a++)
					f.v[i][a] = f.v[0][a] + CW'($urandom_range(0, 8) - 4);
		end else if (kind == 8) begin
			k = $urandom_range(0, 4) - 2;
			for (int a = 0; a < 3; a++) begin
				f.v[1][a] = f.v[0][a] + CW'($urandom_range(0, 2000) - 1000);
				f.v[2][a] = f.v[0][a] + CW'(k * (f.v[1][a] - f.v[0][a]));
			end
		end else if (kind == 9) begin
			for (int i = 0; i < 4; i++)
				for (int a = 0; a < 3; a++)
					f.v[i][a] = corner[$urandom_range(0, 3)];
		end
		return f;
	endfunction

	task automatic random_faces(int n);
		repeat (n) send_face(random_face());
	endtask

	initial begin
		int signed one;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		vert.valid = 1'b0;
		{vert.first_x, vert.first_y, vert.first_z}    = '0;
		{vert.second_x, vert.second_y, vert.second_z} = '0;
		{vert.third_x, vert.third_y, vert.third_z}    = '0;
		{vert.fourth_x, vert.fourth_y, vert.fourth_z} = '0;
		steady   = 1'b0;
		hold_req = 1'b0;
		sent     = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed faces under reset settings (one face per mesh, threshold 1)
		one = 1 << 16;
		send_face(make_face('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
		send_face(make_face('{8388607,8388607,8388607, 8388607,8388607,8388607,
			8388607,8388607,8388607, 8388607,8388607,8388607}));
		send_face(make_face('{-8388608,-8388608,-8388608, -8388608,-8388608,-8388608,
			-8388608,-8388608,-8388608, -8388608,-8388608,-8388608}));
		// axis-aligned squares: normals along +z, +x, +y and reversed winding
		send_face(make_face('{0,0,0, one,0,0, one,one,0, 0,one,0}));
		send_face(make_face('{0,0,0, 0,one,0, 0,one,one, 0,0,one}));
		send_face(make_face('{0,0,0, 0,0,one, one,0,one, one,0,0}));
		send_face(make_face('{0,0,0, 0,one,0, one,one,0, one,0,0}));
		// largest cross product: opposite corners of the coordinate cube
		send_face(make_face('{-8388608,-8388608,-8388608, 8388607,-8388608,8388607,
			-8388608,8388607,8388607, 8388607,8388607,-8388608}));
		send_face(make_face('{8388607,-8388608,0, -8388608,8388607,-8388608,
			8388607,8388607,8388607, -1,-1,-1}));
		// collinear edges: zero cross product
		send_face(make_face('{5,-7,9, 105,-207,309, 205,-407,609, 3,3,3}));
		// smallest nonzero cross product, at the threshold
		send_face(make_face('{0,0,0, 1,0,0, 0,1,0, 0,0,0}));
		send_face(make_face('{0,0,0, 1,0,0, 1,1,0, 0,0,0}));
		send_face(make_face('{0,0,0, 1,1,0, 0,1,0, 0,0,0}));
		// negative sums round toward minus infinity
		send_face(make_face('{-1,-2,-3, 0,0,0, 0,0,-1, 0,-1,0}));
		send_face(make_face('{-8388608,1,-5, -8388608,1,3, 8388607,2,-7, 1,-1,8}));
		// normal with components of nearly equal size, one much smaller
		send_face(make_face('{0,0,0, one,-one,0, 0,one,-one, 7,7,7}));
		send_face(make_face('{0,0,0, 8388607,1,0, 0,8388607,1, 0,0,0}));
		drain();

		write_reg(REG_FACE_COUNT, 3);
		write_reg(REG_MIN_NORM_SQ, 0);
		random_faces(200);
		drain();

		// largest threshold, which marks small and collinear faces degenerate
		write_reg(REG_FACE_COUNT, 7);
		write_reg(REG_MIN_NORM_SQ, {THRESH_W{1'b1}});
		random_faces(80);
		drain();

		// mid threshold, 65535-face mesh, receiver holds off while faces keep coming
		write_reg(REG_FACE_COUNT, 65535);
		write_reg(REG_MIN_NORM_SQ, 63'd1 << 40);
		hold_req = 1'b1;
		random_faces(200);
		drain();

		// face_count zero means 65536 faces
		write_reg(REG_FACE_COUNT, 0);
		write_reg(REG_MIN_NORM_SQ, 1);
		random_faces(150);
		drain();

		// no idling at all on either side
		steady = 1'b1;
		write_reg(REG_FACE_COUNT, 5);
		random_faces(200);
		steady = 1'b0;
		drain();

		// lower face_count below the running index, then raise it again
		random_faces(3);
		drain();
		write_reg(REG_FACE_COUNT, 2);
		random_faces(20);
		drain();
		write_reg(REG_FACE_COUNT, 30);
		random_faces(60);
		drain();

		$display("covered %0d faces, %0d results checked, %0d degenerate, %0d mesh ends",
			sent, board.checked, board.degen_seen, board.last_seen);
		$display("settings: face_count 1/2/3/5/7/30/65535/0, threshold 0/1/2^40/max");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
